>>> rtl/pse_pkg.sv
// Package for the prime sieve engine: sizes, payload structs, codes and FSM states.
// Used by prime_sieve_engine_core, sieve_answer_checker and the testbench.
package pse_pkg;

    localparam int MAX_BOUND = 1024;
    localparam int ADDR_W    = $clog2(MAX_BOUND);
    localparam int BOUND_W   = ADDR_W + 1;
    // Wide enough to hold the first base whose square reaches MAX_BOUND.
    localparam int BASE_W    = ADDR_W / 2 + 1;
    localparam int SQ_W      = 2 * BASE_W;

    localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(1000);
    localparam logic [BOUND_W-1:0] BOUND_MAX   = BOUND_W'(MAX_BOUND);
    localparam logic [BASE_W-1:0]  FIRST_BASE  = BASE_W'(2);

    typedef enum logic {
        ACT_SIEVE = 1'b0,
        ACT_QUERY = 1'b1
    } t_action;

    typedef enum logic {
        KIND_DONE   = 1'b0,
        KIND_ANSWER = 1'b1
    } t_kind;

    typedef struct packed {
        t_action           action;
        logic [ADDR_W-1:0] number;
    } t_in_word;

    typedef struct packed {
        t_kind kind;
        logic  is_prime;
        logic  in_range;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_BASE,
        ST_MARK,
        ST_DONE,
        ST_QUERY
    } t_state;

endpackage

>>> rtl/pse_flag_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Generic; holds the primality map of the prime sieve engine.
module pse_flag_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/prime_sieve_engine_core.sv
// Top level of the prime sieve engine; depends on pse_pkg and pse_flag_ram.
// Holds the control FSM, the bound registers and the output register.
//
// The engine keeps a one-bit primality map in a 1024-entry RAM. A query word is accepted in
// idle and reads the RAM at that edge; ST_QUERY loads the result when the output is free.
// No new word is taken until the engine is back in idle. A sieve word walks the map through
// the single RAM write port, one entry per cycle: a fill pass over entries 0 to lim-1
// (lim = min(upper_bound, 1024)), then for each base b with b*b < lim a setup step in
// ST_BASE and the clearing of its multiples from b*b up, then a final base check and
// posting of the done word. A new result waits in ST_DONE or ST_QUERY until the previous
// one is taken. Queries use the bound of the last sieve run; before any run they answer
// not prime with in_range cleared. upper_bound may be written only while the engine is idle.
module prime_sieve_engine_core
    import pse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [BOUND_W-1:0]    i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_data
);

    t_state              r_state, n_state;
    logic [BOUND_W-1:0]  r_upper_bound;
    logic [BOUND_W-1:0]  r_sieved_bound;
    logic                r_sieve_valid;
    logic [BOUND_W-1:0]  r_k;
    logic [BASE_W-1:0]   r_base;
    logic                r_q_in_range;
    logic                r_out_valid;
    t_out_word           r_out;

    logic                in_accept;
    logic                out_free;
    logic [BOUND_W-1:0]  eff_bound;
    logic [SQ_W-1:0]     base_sq;
    logic                base_live;
    logic [BOUND_W:0]    k_next_fill;
    logic [BOUND_W:0]    k_next_mark;
    logic                fill_last;
    logic                mark_last;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_wdata;
    logic                ram_re;
    logic                ram_rdata;
    logic                load_out;
    t_out_word           out_next;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign eff_bound = (r_upper_bound > BOUND_MAX) ? BOUND_MAX : r_upper_bound;

    assign base_sq     = r_base * r_base;
    assign base_live   = base_sq < SQ_W'(r_sieved_bound);
    assign k_next_fill = {1'b0, r_k} + (BOUND_W+1)'(1);
    assign k_next_mark = {1'b0, r_k} + (BOUND_W+1)'(r_base);
    assign fill_last   = k_next_fill >= {1'b0, r_sieved_bound};
    assign mark_last   = k_next_mark >= {1'b0, r_sieved_bound};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.action == ACT_SIEVE) ? ST_FILL : ST_QUERY;
                end
            end
            ST_FILL: begin
                if (fill_last) begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                n_state = base_live ? ST_MARK : ST_DONE;
            end
            ST_MARK: begin
                if (mark_last) begin
                    n_state = ST_BASE;
                end
            end
            ST_DONE, ST_QUERY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: RAM controls and the result word.
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_k[ADDR_W-1:0];
        ram_wdata  = 1'b0;
        ram_re     = 1'b0;
        load_out   = 1'b0;
        out_next   = '{kind: KIND_DONE, is_prime: 1'b0, in_range: 1'b0};
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_re     = i_in_valid && (i_in_data.action == ACT_QUERY);
            end
            ST_FILL: begin
                // Zero and one are never prime; everything else starts as a candidate.
                ram_we    = r_k < BOUND_W'(r_sieved_bound);
                ram_wdata = r_k >= BOUND_W'(2);
            end
            ST_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = 1'b0;
            end
            ST_DONE: begin
                load_out = out_free;
            end
            ST_QUERY: begin
                load_out = out_free;
                out_next = '{kind: KIND_ANSWER,
                             is_prime: r_q_in_range && ram_rdata,
                             in_range: r_q_in_range};
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_upper_bound  <= BOUND_RESET;
            r_sieved_bound <= '0;
            r_sieve_valid  <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_upper_bound <= i_cfg_wr_data;
            end
            if (in_accept && i_in_data.action == ACT_SIEVE) begin
                r_sieved_bound <= eff_bound;
            end
            if (load_out && r_state == ST_DONE) begin
                r_sieve_valid <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk counters and captured query flags.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_k          <= '0;
                    r_base       <= FIRST_BASE;
                    r_q_in_range <= r_sieve_valid &&
                                    ({1'b0, i_in_data.number} < r_sieved_bound);
                end
            end
            ST_FILL: begin
                r_k <= k_next_fill[BOUND_W-1:0];
            end
            ST_BASE: begin
                r_k <= base_sq[BOUND_W-1:0];
            end
            ST_MARK: begin
                r_k <= k_next_mark[BOUND_W-1:0];
                if (mark_last) begin
                    r_base <= r_base + BASE_W'(1);
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
        if (load_out) begin
            r_out <= out_next;
        end
    end

    pse_flag_ram #(
        .DEPTH (MAX_BOUND),
        .WIDTH (1)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_in_data.number),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> tb/sv/sieve_answer_checker.sv
// Checker for prime_sieve_engine_core: watches the config, input and output channels.
// Keeps its own primality map and bound state and compares every result word in order.
// Depends on pse_pkg for the word types, codes and sizes.
module sieve_answer_checker
    import pse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [BOUND_W-1:0] i_cfg_wr_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  t_in_word           i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  t_out_word          i_out_data,
    output int unsigned        o_fail_count,
    output int unsigned        o_pending,
    output int unsigned        o_prime_answers
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BOUND_W-1:0] bound_shadow;
    logic [BOUND_W-1:0] sieved_limit;
    logic               map_written;
    bit                 primality [MAX_BOUND];
    t_out_word          answers_due [$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_prime_answers = 0;
    end

    task automatic report_mismatch(string msg);
        o_fail_count++;
        $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    // Rebuilds the map the way a sieve word does; bounds above the map size saturate.
    function automatic void rebuild_primality(logic [BOUND_W-1:0] bound);
        int lim;
        int b;
        int k;
        lim = (bound > BOUND_MAX) ? MAX_BOUND : int'(bound);
        for (k = 0; k < lim; k++) primality[k] = 1'b1;
        primality[0] = 1'b0;
        primality[1] = 1'b0;
        for (b = 2; b * b < lim; b++) begin
            for (k = b * b; k < lim; k += b) primality[k] = 1'b0;
        end
        sieved_limit = BOUND_W'(lim);
        map_written  = 1'b1;
    endfunction

    function automatic t_out_word predict_answer(t_in_word w);
        t_out_word r;
        r = '0;
        if (w.action == ACT_SIEVE) begin
            rebuild_primality(bound_shadow);
            r.kind = KIND_DONE;
        end else begin
            r.kind = KIND_ANSWER;
            if (map_written && BOUND_W'(w.number) < sieved_limit) begin
                r.is_prime = primality[w.number];
                r.in_range = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word due;
        t_out_word seen;
        if (!i_rst_n) begin
            bound_shadow = BOUND_RESET;
            sieved_limit = '0;
            map_written  = 1'b0;
            answers_due.delete();
        end else begin
            if (i_cfg_wr_en) bound_shadow = i_cfg_wr_data;
            // Retire the oldest expectation before queuing a new one.
            if (i_out_valid && i_out_ready) begin
                seen = i_out_data;
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("result word %b with nothing outstanding", seen));
                end else begin
                    due = answers_due.pop_front();
                    if (seen.kind !== due.kind)
                        report_mismatch($sformatf("kind: expected %0b got %0b",
                                                  due.kind, seen.kind));
                    if (seen.is_prime !== due.is_prime)
                        report_mismatch($sformatf("is_prime: expected %0b got %0b",
                                                  due.is_prime, seen.is_prime));
                    if (seen.in_range !== due.in_range)
                        report_mismatch($sformatf("in_range: expected %0b got %0b",
                                                  due.in_range, seen.in_range));
                end
            end
            if (i_in_valid && i_in_ready) begin
                due = predict_answer(i_in_data);
                if (due.is_prime) o_prime_answers++;
                answers_due.push_back(due);
            end
        end
        o_pending = answers_due.size();
    end

endmodule

>>> tb/sv/tb_prime_sieve_engine_core.sv
// Testbench top for prime_sieve_engine_core: clock, reset, stimulus and verdict.
// Depends on pse_pkg, the engine RTL and sieve_answer_checker.
module tb_prime_sieve_engine_core
    import pse_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [BOUND_W-1:0] i_cfg_wr_data = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    t_in_word           i_in_data     = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    t_out_word          o_out_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned prime_answers;

    bit          long_hold_req = 1'b0;
    int unsigned burst_left    = 0;
    int unsigned n_sieves      = 0;
    int unsigned n_queries     = 0;
    int unsigned n_bounds      = 0;
    int unsigned random_sent   = 0;
    int          sieved_eff    = 0;
    logic [BOUND_W-1:0] bound_now = BOUND_RESET;

    always #5 i_clk = ~i_clk;

    prime_sieve_engine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    sieve_answer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_data       (i_in_data),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_data      (o_out_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_prime_answers (prime_answers)
    );

    // Sender: bursts of random length separated by random gaps.
    task automatic put_word(t_in_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_query(int unsigned n);
        t_in_word w;
        w.action = ACT_QUERY;
        w.number = ADDR_W'(n);
        put_word(w);
        n_queries++;
    endtask

    task automatic send_sieve();
        t_in_word w;
        // The number field is ignored on a sieve word, so give it random content.
        w.action = ACT_SIEVE;
        w.number = ADDR_W'($urandom);
        put_word(w);
        sieved_eff = (bound_now > BOUND_MAX) ? MAX_BOUND : int'(bound_now);
        n_sieves++;
    endtask

    // Drops valid and waits until every outstanding word has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_bound(logic [BOUND_W-1:0] v);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        bound_now = v;
        n_bounds++;
    endtask

    function automatic logic [BOUND_W-1:0] pick_bound();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 9))
                    0: return BOUND_W'(0);
                    1: return BOUND_W'(1);
                    2: return BOUND_W'(2);
                    3: return BOUND_W'(3);
                    4: return BOUND_W'(5);
                    5: return BOUND_W'(1023);
                    6: return BOUND_MAX;
                    7: return BOUND_W'(1025);
                    8: return BOUND_W'(2047);
                    default: return BOUND_W'(16);
                endcase
            end
            3: return BOUND_W'($urandom_range(0, 2047));
            default: return BOUND_W'($urandom_range(2, 1024));
        endcase
    endfunction

    // Mostly numbers inside the sieved range, some anywhere, some within two of the bound.
    function automatic int unsigned pick_number();
        int unsigned r;
        int t;
        r = $urandom_range(0, 9);
        if (sieved_eff == 0 || (r >= 7 && r < 9)) return $urandom_range(0, MAX_BOUND - 1);
        if (r < 7) return $urandom_range(0, sieved_eff - 1);
        t = sieved_eff + int'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
        if (t > MAX_BOUND - 1) t = MAX_BOUND - 1;
        return t;
    endfunction

    // Receiver: a 16-bit ready mask redrawn each time it has been stepped through, plus one long hold-off.
    initial begin : out_pacing
        logic [15:0] mask;
        int unsigned slot;
        int unsigned held;
        bit          held_once;
        mask      = '1;
        slot      = 0;
        held_once = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !held_once) begin
                held_once = 1'b1;
                i_out_ready <= 1'b0;
                held = 0;
                while (held < 400) begin
                    @(negedge i_clk);
                    held++;
                end
            end else begin
                if (slot == 0) begin
                    case ($urandom_range(0, 3))
                        0: mask = '1;
                        1: mask = 16'($urandom);
                        2: mask = 16'($urandom) | 16'($urandom);
                        default: mask = ~(16'h1 << $urandom_range(0, 15));
                    endcase
                end
                i_out_ready <= mask[slot];
                slot = (slot + 1) % 16;
            end
        end
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned quota;
        int unsigned extra_sieves;
        phase        = 0;
        extra_sieves = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Queries before any sieve has run.
        send_query(0);
        send_query(1023);
        // Sieve at the reset bound, then edges of the map and the bound.
        send_sieve();
        send_query(0);
        send_query(1);
        send_query(2);
        send_query(3);
        send_query(997);
        send_query(999);
        send_query(1000);
        send_query(1023);
        // A bound above the map size saturates.
        set_bound(BOUND_W'(2047));
        send_sieve();
        send_query(1021);
        send_query(1023);
        // A new bound does not apply until the next sieve.
        set_bound(BOUND_W'(5));
        send_query(1021);
        send_sieve();
        send_query(3);
        send_query(4);
        send_query(5);
        // Degenerate bounds of two and below.
        set_bound(BOUND_W'(0));
        send_sieve();
        send_query(0);
        set_bound(BOUND_W'(1));
        send_sieve();
        send_query(0);
        set_bound(BOUND_W'(2));
        send_sieve();
        send_query(1);
        send_query(2);

        while (random_sent < 1000) begin
            set_bound(pick_bound());
            // Now and then keep the old map so queries run against the previous bound.
            if ($urandom_range(0, 4) != 0) begin
                send_sieve();
                random_sent++;
            end
            // The third phase runs into the long receiver hold-off.
            if (phase == 2) long_hold_req = 1'b1;
            quota = $urandom_range(30, 90);
            repeat (quota) begin
                if (extra_sieves < 40 && $urandom_range(0, 29) == 0) begin
                    send_sieve();
                    extra_sieves++;
                end else begin
                    send_query(pick_number());
                end
                random_sent++;
            end
            long_hold_req = 1'b0;
            phase++;
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d sieve runs over %0d bound settings and %0d queries.",
                 n_sieves, n_bounds, n_queries);
        $display("Of those queries, %0d were answered prime.", prime_answers);
        if (fail_count == 0 && pending == 0) begin
            $display("prime_sieve_engine_core verification clean");
        end else begin
            $display("prime_sieve_engine_core verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("Timed out with %0d words outstanding.", pending);
        $display("prime_sieve_engine_core verification failed");
        $finish;
    end

endmodule
